// ===== sv/swsr_pkg.sv =====
// shared types and constants for the stop-and-wait sender control
package swsr_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int TIMER_BITS = 24;
   localparam int WORD_W     = 32;
   localparam int ATT_W      = 4;
   localparam int MINDEV_W   = 16;
   localparam int INITTO_W   = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int KIND_W     = 2;
   // wide enough for the fixed-point sums before saturation
   localparam int WIDE_W     = WORD_W + FRAC_BITS + 3;

   typedef enum logic [1:0] {
      ACT_SEND      = 2'd0,
      ACT_DATA_ACK  = 2'd1,
      ACT_TICK      = 2'd2,
      ACT_HANDSHAKE = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      EV_TRANSMIT = 2'd0,
      EV_ACKED    = 2'd1,
      EV_GAVE_UP  = 2'd2
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ATTEMPTS    = 2'd0,
      CSR_MIN_DEVIATION   = 2'd1,
      CSR_INITIAL_TIMEOUT = 2'd2,
      CSR_INITIAL_WINDOW  = 2'd3
   } csr_index_type;

   localparam logic [ATT_W-1:0]    MAX_ATTEMPTS_RST    = ATT_W'(5);
   localparam logic [MINDEV_W-1:0] MIN_DEVIATION_RST   = MINDEV_W'(10);
   localparam logic [INITTO_W-1:0] INITIAL_TIMEOUT_RST = INITTO_W'(1000);
   localparam logic [WORD_W-1:0]   INITIAL_WINDOW_RST  = {WORD_W{1'b1}};

endpackage

// ===== sv/stop_and_wait_sender_rto.sv =====
// Stop-and-wait ARQ sender control with a smoothed round-trip timeout. Each
// request (send, data ack, tick, handshake ack) is taken into an input
// register, and the whole state update, including the RTT estimate,
// deviation and timeout arithmetic, is done from that register into the
// state registers and the response register. One request can be accepted in
// every clock cycle while no response waits to be taken. A request is held
// back only while a response waits to be taken and the input register is
// full. Configuration writes take effect from the cycle after they are
// issued and are meant for idle periods.
module stop_and_wait_sender_rto (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_action,
   input  logic [swsr_pkg::WORD_W-1:0]          req_ack_number,
   input  logic [swsr_pkg::WORD_W-1:0]          req_receiver_window,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [swsr_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [swsr_pkg::WORD_W-1:0]          rsp_sequence_res,
   output logic [swsr_pkg::ATT_W-1:0]           rsp_attempt,
   output logic [swsr_pkg::WORD_W-1:0]          rsp_timeout_now,
   output logic [swsr_pkg::WORD_W-1:0]          rsp_window_now,
   output logic [swsr_pkg::WORD_W-1:0]          rsp_timeouts_seen,
   output logic [swsr_pkg::WORD_W-1:0]          rsp_retransmissions,
   input  logic                                 csr_write_en,
   input  logic [swsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [swsr_pkg::WORD_W-1:0]          csr_write_data
);

   localparam int WORD_W   = swsr_pkg::WORD_W;
   localparam int WIDE_W   = swsr_pkg::WIDE_W;
   localparam int ATT_W    = swsr_pkg::ATT_W;
   localparam int FRAC     = swsr_pkg::FRAC_BITS;
   localparam int TIMER_W  = swsr_pkg::TIMER_BITS;

   function automatic logic [WORD_W-1:0] sat_word(input logic [WIDE_W-1:0] v);
      return (|v[WIDE_W-1:WORD_W]) ? {WORD_W{1'b1}} : v[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] inc_sat(input logic [WORD_W-1:0] v);
      return (v == {WORD_W{1'b1}}) ? v : v + WORD_W'(1);
   endfunction

   // input register
   logic                       in_valid_ff;
   swsr_pkg::action_type       in_action_ff;
   logic [WORD_W-1:0]          in_ack_ff;
   logic [WORD_W-1:0]          in_rwnd_ff;

   // configuration
   logic [ATT_W-1:0]               max_att_ff;
   logic [swsr_pkg::MINDEV_W-1:0]  min_dev_ff;

   // protocol state
   logic [WORD_W-1:0]   base_ff,      base_in;
   logic                waiting_ff,   waiting_in;
   logic [ATT_W-1:0]    attempt_ff,   attempt_in;
   logic [TIMER_W-1:0]  elapsed_ff,   elapsed_in;
   logic [WORD_W-1:0]   srtt_ff,      srtt_in;
   logic [WORD_W-1:0]   rttvar_ff,    rttvar_in;
   logic [WORD_W-1:0]   rto_ff,       rto_in;
   logic [WORD_W-1:0]   window_ff,    window_in;
   logic [WORD_W-1:0]   tmo_total_ff, tmo_total_in;
   logic [WORD_W-1:0]   rtx_total_ff, rtx_total_in;

   // response register
   logic                      rsp_valid_ff;
   swsr_pkg::event_type       rsp_kind_ff;
   logic [WORD_W-1:0]         rsp_seq_ff;
   logic [ATT_W-1:0]          rsp_att_ff;
   logic [WORD_W-1:0]         rsp_rto_ff;
   logic [WORD_W-1:0]         rsp_win_ff;
   logic [WORD_W-1:0]         rsp_tmo_ff;
   logic [WORD_W-1:0]         rsp_rtx_ff;

   logic                      out_free;
   logic                      stage_fire;
   logic                      res_valid;
   swsr_pkg::event_type       res_kind;
   logic [WORD_W-1:0]         res_seq;
   logic [ATT_W-1:0]          res_att;

   // datapath terms
   logic [WIDE_W-1:0]   sample_w;
   logic [WIDE_W-1:0]   est_sum;
   logic [WORD_W-1:0]   est_new;
   logic [WIDE_W-1:0]   diff_w;
   logic [WIDE_W-1:0]   dev_sum;
   logic [WORD_W-1:0]   dev_new;
   logic [WORD_W-1:0]   floor_dev;
   logic [WORD_W-1:0]   dev_term;
   logic [WORD_W-1:0]   rto_ack;
   logic [WORD_W-1:0]   hs_srtt;
   logic [WORD_W-1:0]   hs_rto;
   logic [TIMER_W-1:0]  elapsed_inc;
   logic                tick_expired;
   logic                at_limit;
   logic                ack_match;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stage_fire = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || stage_fire;

   always_comb begin
      sample_w  = WIDE_W'(elapsed_ff) << FRAC;
      est_sum   = (WIDE_W'(srtt_ff) << 3) - WIDE_W'(srtt_ff) + sample_w;
      est_new   = sat_word(est_sum >> 3);
      // deviation is measured against the new estimate
      diff_w    = (sample_w >= WIDE_W'(est_new)) ? sample_w - WIDE_W'(est_new)
                                                 : WIDE_W'(est_new) - sample_w;
      dev_sum   = (WIDE_W'(rttvar_ff) << 1) + WIDE_W'(rttvar_ff) + diff_w;
      dev_new   = sat_word(dev_sum >> 2);
      floor_dev = WORD_W'(min_dev_ff) << FRAC;
      dev_term  = (dev_new > floor_dev) ? dev_new : floor_dev;
      rto_ack   = sat_word(WIDE_W'(est_new) + (WIDE_W'(dev_term) << 2));
      hs_srtt   = sat_word(sample_w);
      hs_rto    = sat_word((WIDE_W'(hs_srtt) << 1) + WIDE_W'(hs_srtt));
      elapsed_inc  = (elapsed_ff == {TIMER_W{1'b1}}) ? elapsed_ff
                                                     : elapsed_ff + TIMER_W'(1);
      tick_expired = (WIDE_W'(elapsed_inc) << FRAC) >= WIDE_W'(rto_ff);
      // a limit of zero behaves like one
      at_limit     = ({1'b0, attempt_ff} + (ATT_W+1)'(1)) >= {1'b0, max_att_ff};
      ack_match    = waiting_ff && (in_ack_ff == base_ff + WORD_W'(1));
   end

   always_comb begin
      base_in      = base_ff;
      waiting_in   = waiting_ff;
      attempt_in   = attempt_ff;
      elapsed_in   = elapsed_ff;
      srtt_in      = srtt_ff;
      rttvar_in    = rttvar_ff;
      rto_in       = rto_ff;
      window_in    = window_ff;
      tmo_total_in = tmo_total_ff;
      rtx_total_in = rtx_total_ff;
      res_valid    = 1'b0;
      res_kind     = swsr_pkg::EV_TRANSMIT;
      res_seq      = base_ff;
      res_att      = attempt_ff;
      case (in_action_ff)
         swsr_pkg::ACT_SEND: begin
            waiting_in = 1'b1;
            attempt_in = '0;
            elapsed_in = '0;
            res_valid  = 1'b1;
            res_att    = '0;
         end
         swsr_pkg::ACT_DATA_ACK: begin
            if (ack_match) begin
               srtt_in    = est_new;
               rttvar_in  = dev_new;
               rto_in     = rto_ack;
               if (in_rwnd_ff < window_ff) begin
                  window_in = in_rwnd_ff;
               end
               base_in    = base_ff + WORD_W'(1);
               waiting_in = 1'b0;
               elapsed_in = '0;
               res_valid  = 1'b1;
               res_kind   = swsr_pkg::EV_ACKED;
            end
         end
         swsr_pkg::ACT_TICK: begin
            elapsed_in = elapsed_inc;
            if (waiting_ff && tick_expired) begin
               res_valid  = 1'b1;
               elapsed_in = '0;
               if (at_limit) begin
                  waiting_in = 1'b0;
                  res_kind   = swsr_pkg::EV_GAVE_UP;
               end else begin
                  tmo_total_in = inc_sat(tmo_total_ff);
                  rtx_total_in = inc_sat(rtx_total_ff);
                  attempt_in   = attempt_ff + ATT_W'(1);
                  res_att      = attempt_ff + ATT_W'(1);
               end
            end
         end
         swsr_pkg::ACT_HANDSHAKE: begin
            srtt_in = hs_srtt;
            rto_in  = hs_rto;
            if (!waiting_ff) begin
               elapsed_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_att_ff   <= swsr_pkg::MAX_ATTEMPTS_RST;
         min_dev_ff   <= swsr_pkg::MIN_DEVIATION_RST;
         base_ff      <= '0;
         waiting_ff   <= 1'b0;
         attempt_ff   <= '0;
         elapsed_ff   <= '0;
         srtt_ff      <= '0;
         rttvar_ff    <= '0;
         rto_ff       <= sat_word(WIDE_W'(swsr_pkg::INITIAL_TIMEOUT_RST) << FRAC);
         window_ff    <= swsr_pkg::INITIAL_WINDOW_RST;
         tmo_total_ff <= '0;
         rtx_total_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (stage_fire) begin
            base_ff      <= base_in;
            waiting_ff   <= waiting_in;
            attempt_ff   <= attempt_in;
            elapsed_ff   <= elapsed_in;
            srtt_ff      <= srtt_in;
            rttvar_ff    <= rttvar_in;
            rto_ff       <= rto_in;
            window_ff    <= window_in;
            tmo_total_ff <= tmo_total_in;
            rtx_total_ff <= rtx_total_in;
         end
         if (out_free) begin
            rsp_valid_ff <= stage_fire && res_valid;
         end
         if (csr_write_en) begin
            case (swsr_pkg::csr_index_type'(csr_index))
               swsr_pkg::CSR_MAX_ATTEMPTS: begin
                  max_att_ff <= csr_write_data[ATT_W-1:0];
               end
               swsr_pkg::CSR_MIN_DEVIATION: begin
                  min_dev_ff <= csr_write_data[swsr_pkg::MINDEV_W-1:0];
               end
               swsr_pkg::CSR_INITIAL_TIMEOUT: begin
                  rto_ff     <= sat_word(WIDE_W'(csr_write_data[swsr_pkg::INITTO_W-1:0])
                                         << FRAC);
               end
               swsr_pkg::CSR_INITIAL_WINDOW: begin
                  window_ff   <= csr_write_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_action_ff <= swsr_pkg::action_type'(req_action);
         in_ack_ff    <= req_ack_number;
         in_rwnd_ff   <= req_receiver_window;
      end
      if (stage_fire && res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_seq_ff  <= res_seq;
         rsp_att_ff  <= res_att;
         rsp_rto_ff  <= rto_in;
         rsp_win_ff  <= window_in;
         rsp_tmo_ff  <= tmo_total_in;
         rsp_rtx_ff  <= rtx_total_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = rsp_kind_ff;
   assign rsp_sequence_res    = rsp_seq_ff;
   assign rsp_attempt         = rsp_att_ff;
   assign rsp_timeout_now     = rsp_rto_ff;
   assign rsp_window_now      = rsp_win_ff;
   assign rsp_timeouts_seen   = rsp_tmo_ff;
   assign rsp_retransmissions = rsp_rtx_ff;

endmodule

// ===== sv/swsr_checker.sv =====
// port-level checks for the stop-and-wait sender control, bound to the top level
module swsr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [swsr_pkg::KIND_W-1:0]       rsp_event_kind,
   input logic [swsr_pkg::WORD_W-1:0]       rsp_sequence_res,
   input logic [swsr_pkg::WORD_W-1:0]       rsp_timeouts_seen,
   input logic [swsr_pkg::WORD_W-1:0]       rsp_retransmissions
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sequence_res)
                                 && $stable(rsp_event_kind))
      else $error("response changed while stalled");

   // every timeout below the limit is also a retransmission
   a_totals_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_timeouts_seen == rsp_retransmissions)
      else $error("timeout and retransmission totals differ");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind == swsr_pkg::EV_TRANSMIT
                 || rsp_event_kind == swsr_pkg::EV_ACKED
                 || rsp_event_kind == swsr_pkg::EV_GAVE_UP)
      else $error("undefined event kind");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the output free, the input side never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with idle output");

endmodule

bind stop_and_wait_sender_rto swsr_checker u_swsr_checker (.*);
